### sv/wso_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wso_pkg
// shared types, widths and constants of the wavetable sine oscillator
// ----------------------------------------------------------------------------
`default_nettype none

package wso_pkg;

    localparam int FREQ_W  = 18;
    localparam int RATE_W  = 18;
    localparam int DEN_W   = RATE_W + 4;
    localparam int PER_W   = 16;
    localparam int IDX_W   = 16;
    localparam int PHASE_W = 32;
    localparam int Q       = 30;
    localparam int X_W     = Q + 1;
    localparam int MUL_W   = 33;
    localparam int P_W     = 2 * MUL_W;
    localparam int DIV_N_W = FREQ_W + PHASE_W;
    localparam int DIV_D_W = DEN_W;

    localparam int INDEX_BITS_DEF  = 16;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(44100);
    localparam logic [PER_W-1:0]  PER_MAX    = '1;
    localparam logic [X_W-1:0]    Q_ONE      = {1'b1, {Q{1'b0}}};

    localparam int HORN_CNT_W = 2;
    localparam logic [HORN_CNT_W-1:0] HORN_LAST = '1;
    localparam logic signed [MUL_W-1:0] HORNER_SEED = MUL_W'(172272);

    localparam logic REQ_SET  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam int ST_DEPTH = 1;
    localparam int ST_AW    = 1;
    localparam logic [ST_AW-1:0] ST_ADDR = '0;

    typedef struct packed {
        logic [FREQ_W-1:0]  cur_freq;
        logic [PER_W-1:0]   period_len;
        logic [IDX_W-1:0]   phase_index;
        logic [PHASE_W-1:0] phase_step;
    } st_t;

    localparam st_t ST_RESET = '{
        cur_freq:    '0,
        period_len:  PER_W'(1),
        phase_index: '0,
        phase_step:  '0
    };

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quot;
        logic [DIV_D_W-1:0] rem;
    } div_rsp_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOAD,
        S_CMP,
        S_DPER,
        S_DSTEP,
        S_WRAP,
        S_DWRAP,
        S_PH,
        S_X,
        S_X2,
        S_X2R,
        S_HM,
        S_HA,
        S_YM,
        S_YA,
        S_AM,
        S_AA,
        S_WB
    } state_t;

    function automatic logic signed [MUL_W-1:0] horner_coef(input logic [HORN_CNT_W-1:0] k);
        logic signed [MUL_W-1:0] c;
        case (k)
            2'd0:    c = MUL_W'(-5026994);
            2'd1:    c = MUL_W'(85569307);
            2'd2:    c = MUL_W'(-693598673);
            default: c = MUL_W'(1686629713);
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### sv/wso_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wso channel interfaces
// request, sample and configuration channels with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface wso_req_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [wso_pkg::FREQ_W-1:0]  freq_q4;

    modport source (output valid, output req_type, output freq_q4, input ready);
    modport sink   (input valid, input req_type, input freq_q4, output ready);
endinterface

interface wso_smp_if #(
    parameter int SAMPLE_BITS = wso_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface wso_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [wso_pkg::RATE_W-1:0]  sample_rate;

    modport source (output valid, output sample_rate, input ready);
    modport sink   (input valid, input sample_rate, output ready);
endinterface

`default_nettype wire

### sv/wso_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wso_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module wso_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### sv/wso_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wso_mul
// shared signed multiplier with a registered product
// ----------------------------------------------------------------------------
`default_nettype none

module wso_mul (
    input  logic                                clk,
    input  logic signed [wso_pkg::MUL_W-1:0]    a,
    input  logic signed [wso_pkg::MUL_W-1:0]    b,
    output logic signed [wso_pkg::P_W-1:0]      p
);

    logic signed [wso_pkg::P_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

### sv/wso_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wso_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module wso_div (
    input  logic              clk,
    input  logic              rst_n,
    input  wso_pkg::div_req_t req,
    output wso_pkg::div_rsp_t rsp
);

    localparam int N_W   = wso_pkg::DIV_N_W;
    localparam int D_W   = wso_pkg::DIV_D_W;
    localparam int CNT_W = $clog2(N_W + 1);

    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   rem_next;
    logic [N_W-1:0]   quo_reg;
    logic [N_W-1:0]   quo_next;
    logic [D_W-1:0]   dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [D_W:0]     trial;
    logic             fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[N_W-1]};
        fits  = trial >= {1'b0, dsr_reg};
        if (fits)
        begin
            rem_next = D_W'(trial - {1'b0, dsr_reg});
        end
        else
        begin
            rem_next = trial[D_W-1:0];
        end
        quo_next = {quo_reg[N_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(N_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    always_comb
    begin
        rsp.done = done_reg;
        rsp.quot = quo_reg;
        rsp.rem  = rem_reg;
    end

endmodule

`default_nettype wire

### sv/wavetable_sine_oscillator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavetable_sine_oscillator_unit
// tick: the shared multiplier runs phase, x^2, four horner steps, y and scaling
// in turn between request transfer and the next ready
// set with a new frequency: three divisions with 50-bit quotients in turn, or
// one division when the frequency or the rate is zero
// set with the stored frequency: compare only; one request at a time
// reset: async active low; state reads as its reset values until first write
// ----------------------------------------------------------------------------
`default_nettype none

module wavetable_sine_oscillator_unit #(
    parameter int INDEX_BITS  = wso_pkg::INDEX_BITS_DEF,
    parameter int SAMPLE_BITS = wso_pkg::SAMPLE_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    wso_req_if.sink   req,
    wso_cfg_if.sink   cfg,
    wso_smp_if.source smp
);

    localparam int MUL_W   = wso_pkg::MUL_W;
    localparam int P_W     = wso_pkg::P_W;
    localparam int Q       = wso_pkg::Q;
    localparam int X_W     = wso_pkg::X_W;
    localparam int PHASE_W = wso_pkg::PHASE_W;
    localparam int PER_W   = wso_pkg::PER_W;
    localparam int IDX_W   = wso_pkg::IDX_W;
    localparam int FREQ_W  = wso_pkg::FREQ_W;
    localparam int DEN_W   = wso_pkg::DEN_W;
    localparam int N_W     = wso_pkg::DIV_N_W;
    localparam int D_W     = wso_pkg::DIV_D_W;

    localparam logic [MUL_W-1:0] AMP = MUL_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [P_W-1:0] RND_HALF  = P_W'(1) << (Q - 1);
    localparam logic signed [P_W-1:0] TRUNC_ADJ = (P_W'(1) << Q) - P_W'(1);

    wso_pkg::state_t state_reg;
    wso_pkg::state_t state_next;

    logic                     st_valid_reg;
    logic [wso_pkg::RATE_W-1:0] sample_rate_reg;
    logic                     out_valid_reg;
    logic [wso_pkg::HORN_CNT_W-1:0] cnt_reg;

    logic                     req_type_reg;
    logic [FREQ_W-1:0]        fin_reg;
    logic [FREQ_W-1:0]        freq_reg;
    logic [PER_W-1:0]         per_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [PHASE_W-1:0]       step_reg;
    logic [1:0]               quad_reg;
    logic [X_W-1:0]           x_reg;
    logic [X_W-1:0]           x2_reg;
    logic signed [MUL_W-1:0]  r_reg;
    logic [X_W-1:0]           y_reg;
    logic [SAMPLE_BITS-1:0]   res_reg;
    logic [SAMPLE_BITS-1:0]   sample_reg;

    logic                     req_fire;
    logic                     out_free;
    logic                     out_load;
    logic                     ram_re;
    logic                     ram_we;
    logic [$bits(wso_pkg::st_t)-1:0] ram_rdata;
    wso_pkg::st_t             ld_st;
    wso_pkg::st_t             wb_st;
    logic [DEN_W-1:0]         den;
    logic                     freq_change;
    logic                     need_div;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [P_W-1:0]    mul_p;

    wso_pkg::div_req_t        div_req;
    wso_pkg::div_rsp_t        div_rsp;

    logic [PHASE_W-1:0]       phase_w;
    logic [INDEX_BITS-1:0]    pidx_w;
    logic [Q-1:0]             xf_w;
    logic [X_W-1:0]           x_w;
    logic signed [P_W-1:0]    adj_w;
    logic signed [P_W-1:0]    tq_w;
    logic signed [MUL_W-1:0]  tq_r;
    logic [X_W-1:0]           y_w;
    logic signed [P_W-1:0]    rnd_w;
    logic [SAMPLE_BITS-1:0]   s_w;
    logic [SAMPLE_BITS-1:0]   res_w;
    logic [PER_W-1:0]         per_sat;
    logic [PHASE_W-1:0]       step_sat;
    logic [IDX_W:0]           idx_plus;
    logic [IDX_W-1:0]         idx_inc;

    wso_ram #(
        .WIDTH ($bits(wso_pkg::st_t)),
        .DEPTH (wso_pkg::ST_DEPTH)
    ) u_st_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wso_pkg::ST_ADDR),
        .wdata (wb_st),
        .re    (ram_re),
        .raddr (wso_pkg::ST_ADDR),
        .rdata (ram_rdata)
    );

    wso_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    wso_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // datapath helpers
    always_comb
    begin
        req_fire    = req.valid && req.ready;
        out_free    = !out_valid_reg || smp.ready;
        den         = {sample_rate_reg, 4'b0000};
        freq_change = fin_reg != freq_reg;
        need_div    = freq_change && (fin_reg != '0) && (den != '0);
        ld_st       = st_valid_reg ? wso_pkg::st_t'(ram_rdata) : wso_pkg::ST_RESET;
        wb_st       = '{cur_freq: freq_reg, period_len: per_reg,
                        phase_index: idx_reg, phase_step: step_reg};

        phase_w = mul_p[PHASE_W-1:0];
        pidx_w  = phase_w[PHASE_W-1 -: INDEX_BITS];
        xf_w    = {pidx_w[INDEX_BITS-3:0], {(PHASE_W - INDEX_BITS){1'b0}}};
        if (pidx_w[INDEX_BITS-2])
        begin
            x_w = wso_pkg::Q_ONE - {1'b0, xf_w};
        end
        else
        begin
            x_w = {1'b0, xf_w};
        end

        // product divided by 2^30, truncated toward zero
        adj_w = mul_p + (mul_p[P_W-1] ? TRUNC_ADJ : '0);
        tq_w  = adj_w >>> Q;
        tq_r  = tq_w[MUL_W-1:0];

        if (tq_r[MUL_W-1])
        begin
            y_w = '0;
        end
        else if (tq_r[MUL_W-2:0] > (MUL_W-1)'(wso_pkg::Q_ONE))
        begin
            y_w = wso_pkg::Q_ONE;
        end
        else
        begin
            y_w = tq_r[X_W-1:0];
        end

        rnd_w = (mul_p + RND_HALF) >>> Q;
        s_w   = rnd_w[SAMPLE_BITS-1:0];
        res_w = quad_reg[1] ? ({SAMPLE_BITS{1'b0}} - s_w) : s_w;

        if (div_rsp.quot == '0)
        begin
            per_sat = PER_W'(1);
        end
        else if (|div_rsp.quot[N_W-1:PER_W])
        begin
            per_sat = wso_pkg::PER_MAX;
        end
        else
        begin
            per_sat = div_rsp.quot[PER_W-1:0];
        end
        step_sat = (|div_rsp.quot[N_W-1:PHASE_W]) ? '1 : div_rsp.quot[PHASE_W-1:0];

        idx_plus = {1'b0, idx_reg} + 1'b1;
        idx_inc  = (idx_plus == {1'b0, per_reg}) ? '0 : idx_plus[IDX_W-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wso_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = wso_pkg::S_LOAD;
                end
            end
            wso_pkg::S_LOAD:
            begin
                state_next = (req_type_reg == wso_pkg::REQ_TICK) ? wso_pkg::S_PH
                                                                 : wso_pkg::S_CMP;
            end
            wso_pkg::S_CMP:
            begin
                if (!freq_change)
                begin
                    state_next = wso_pkg::S_IDLE;
                end
                else if (need_div)
                begin
                    state_next = wso_pkg::S_DPER;
                end
                else
                begin
                    state_next = wso_pkg::S_WRAP;
                end
            end
            wso_pkg::S_DPER:
            begin
                if (div_rsp.done)
                begin
                    state_next = wso_pkg::S_DSTEP;
                end
            end
            wso_pkg::S_DSTEP:
            begin
                if (div_rsp.done)
                begin
                    state_next = wso_pkg::S_WRAP;
                end
            end
            wso_pkg::S_WRAP:  state_next = wso_pkg::S_DWRAP;
            wso_pkg::S_DWRAP:
            begin
                if (div_rsp.done)
                begin
                    state_next = wso_pkg::S_WB;
                end
            end
            wso_pkg::S_PH:    state_next = wso_pkg::S_X;
            wso_pkg::S_X:     state_next = wso_pkg::S_X2;
            wso_pkg::S_X2:    state_next = wso_pkg::S_X2R;
            wso_pkg::S_X2R:   state_next = wso_pkg::S_HM;
            wso_pkg::S_HM:    state_next = wso_pkg::S_HA;
            wso_pkg::S_HA:
            begin
                state_next = (cnt_reg == wso_pkg::HORN_LAST) ? wso_pkg::S_YM
                                                             : wso_pkg::S_HM;
            end
            wso_pkg::S_YM:    state_next = wso_pkg::S_YA;
            wso_pkg::S_YA:    state_next = wso_pkg::S_AM;
            wso_pkg::S_AM:    state_next = wso_pkg::S_AA;
            wso_pkg::S_AA:    state_next = wso_pkg::S_WB;
            wso_pkg::S_WB:
            begin
                if ((req_type_reg == wso_pkg::REQ_SET) || out_free)
                begin
                    state_next = wso_pkg::S_IDLE;
                end
            end
            default:          state_next = wso_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        ram_re           = 1'b0;
        ram_we           = 1'b0;
        out_load         = 1'b0;
        mul_a            = '0;
        mul_b            = '0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        case (state_reg)
            wso_pkg::S_IDLE:
            begin
                ram_re = req_fire;
            end
            wso_pkg::S_CMP:
            begin
                div_req.start    = need_div;
                div_req.dividend = N_W'(den);
                div_req.divisor  = D_W'(fin_reg);
            end
            wso_pkg::S_DPER:
            begin
                div_req.start    = div_rsp.done;
                div_req.dividend = {fin_reg, {PHASE_W{1'b0}}};
                div_req.divisor  = den;
            end
            wso_pkg::S_WRAP:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = N_W'(idx_reg);
                div_req.divisor  = D_W'(per_reg);
            end
            wso_pkg::S_PH:
            begin
                mul_a = MUL_W'(idx_reg);
                mul_b = MUL_W'(step_reg);
            end
            wso_pkg::S_X2:
            begin
                mul_a = MUL_W'(x_reg);
                mul_b = MUL_W'(x_reg);
            end
            wso_pkg::S_HM:
            begin
                mul_a = r_reg;
                mul_b = MUL_W'(x2_reg);
            end
            wso_pkg::S_YM:
            begin
                mul_a = r_reg;
                mul_b = MUL_W'(x_reg);
            end
            wso_pkg::S_AM:
            begin
                mul_a = MUL_W'(y_reg);
                mul_b = AMP;
            end
            wso_pkg::S_WB:
            begin
                ram_we   = 1'b1;
                out_load = (req_type_reg == wso_pkg::REQ_TICK) && out_free;
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= wso_pkg::S_IDLE;
            st_valid_reg    <= 1'b0;
            sample_rate_reg <= wso_pkg::RATE_RESET;
            out_valid_reg   <= 1'b0;
            cnt_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ram_we)
            begin
                st_valid_reg <= 1'b1;
            end
            if (cfg.valid && cfg.ready)
            begin
                sample_rate_reg <= cfg.sample_rate;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (smp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == wso_pkg::S_X2R)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == wso_pkg::S_HA)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            wso_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    req_type_reg <= req.req_type;
                    fin_reg      <= req.freq_q4;
                end
            end
            wso_pkg::S_LOAD:
            begin
                freq_reg <= ld_st.cur_freq;
                per_reg  <= ld_st.period_len;
                idx_reg  <= ld_st.phase_index;
                step_reg <= ld_st.phase_step;
            end
            wso_pkg::S_CMP:
            begin
                if (freq_change)
                begin
                    freq_reg <= fin_reg;
                    if (fin_reg == '0)
                    begin
                        per_reg  <= wso_pkg::PER_MAX;
                        step_reg <= '0;
                    end
                    else if (den == '0)
                    begin
                        per_reg  <= PER_W'(1);
                        step_reg <= '1;
                    end
                end
            end
            wso_pkg::S_DPER:
            begin
                if (div_rsp.done)
                begin
                    per_reg <= per_sat;
                end
            end
            wso_pkg::S_DSTEP:
            begin
                if (div_rsp.done)
                begin
                    step_reg <= step_sat;
                end
            end
            wso_pkg::S_DWRAP:
            begin
                if (div_rsp.done)
                begin
                    idx_reg <= div_rsp.rem[IDX_W-1:0];
                end
            end
            wso_pkg::S_X:
            begin
                quad_reg <= pidx_w[INDEX_BITS-1 -: 2];
                x_reg    <= x_w;
            end
            wso_pkg::S_X2R:
            begin
                x2_reg <= mul_p[Q +: X_W];
                r_reg  <= wso_pkg::HORNER_SEED;
            end
            wso_pkg::S_HA:
            begin
                r_reg <= wso_pkg::horner_coef(cnt_reg) + tq_r;
            end
            wso_pkg::S_YA:
            begin
                y_reg <= y_w;
            end
            wso_pkg::S_AA:
            begin
                res_reg <= res_w;
                idx_reg <= idx_inc;
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
        if (out_load)
        begin
            sample_reg <= res_reg;
        end
    end

    assign req.ready  = (state_reg == wso_pkg::S_IDLE);
    assign cfg.ready  = 1'b1;
    assign smp.valid  = out_valid_reg;
    assign smp.sample = sample_reg;

    // phase index always inside the period when written back
    a_wb_index_in_period: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wso_pkg::S_WB) |-> (per_reg != '0) && (idx_reg < per_reg))
        else $error("phase index outside period at writeback");

    // divider results only arrive while a division is awaited
    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == wso_pkg::S_DPER) || (state_reg == wso_pkg::S_DSTEP)
                         || (state_reg == wso_pkg::S_DWRAP))
        else $error("divider result with no division pending");

    // a request transfer always reads the state memory next
    a_req_loads_state: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg == wso_pkg::S_LOAD))
        else $error("request transfer not followed by state load");

    // the horner loop runs exactly four steps before y
    a_horner_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wso_pkg::S_YM) |-> ($past(state_reg) == wso_pkg::S_HA)
                                         && ($past(cnt_reg) == wso_pkg::HORN_LAST))
        else $error("horner loop left early");

endmodule

`default_nettype wire

### bench/wavetable_sine_oscillator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavetable_sine_oscillator_unit_tb
// drives set and tick requests through the request channel and rewrites the
// sample rate between phases. An independent sine predictor tracks frequency,
// period, phase index and phase step, and queues the Q1.15 sample due for each
// accepted tick. Every sample transfer is checked against the oldest queued
// sample. Sender and receiver idle at random, the receiver also stalls for
// long stretches, and a watchdog ends runs that stop moving.
// ----------------------------------------------------------------------------
module wavetable_sine_oscillator_unit_tb;
    import wso_pkg::*;

    localparam int     SMP_W          = SAMPLE_BITS_DEF;
    localparam int     ITEMS_PER_PHASE = 190;
    localparam int     MODE_SPLIT      = 383;
    localparam int     HOLD_CYCLES     = 300;
    localparam int     SETTLE_CYCLES   = 400;
    localparam int     WATCHDOG_LIMIT  = 4000;
    localparam int     MAX_REPORTS     = 10;
    localparam longint ONE_Q30         = 64'sd1073741824;
    localparam longint HALF_Q30        = 64'sd536870912;
    localparam longint PER_SAT         = 64'sd65535;
    localparam longint STEP_SAT        = 64'sd4294967295;
    localparam longint AMP             = (64'sd1 <<< (SMP_W - 1)) - 1;
    localparam longint C1              = 64'sd1686629713;
    localparam longint C3              = -64'sd693598673;
    localparam longint C5              = 64'sd85569307;
    localparam longint C7              = -64'sd5026994;
    localparam longint C9              = 64'sd172272;

    class tone_checker;
        logic [RATE_W-1:0]           rate;
        logic [FREQ_W-1:0]           cur_freq;
        logic [PER_W-1:0]            period_len;
        logic [IDX_W-1:0]            phase_index;
        logic [PHASE_W-1:0]          phase_step;
        logic signed [SMP_W-1:0]     due_samples[$];
        int                          errors;

        function new();
            rate        = RATE_RESET;
            cur_freq    = '0;
            period_len  = PER_W'(1);
            phase_index = '0;
            phase_step  = '0;
            errors      = 0;
        endfunction

        function void note_request(logic req_type, logic [FREQ_W-1:0] freq);
            longint             den;
            longint             per;
            longint             stp;
            longint             x;
            longint             x2;
            longint             r;
            longint             y;
            longint             s;
            logic [31:0]        ph;
            logic [1:0]         quad;
            if (req_type == REQ_SET) begin
                if (freq == cur_freq)
                    return;
                den      = longint'(rate) * 16;
                cur_freq = freq;
                if (freq == 0) begin
                    per = PER_SAT;
                    stp = 0;
                end
                else begin
                    per = den / longint'(freq);
                    if (per < 1)
                        per = 1;
                    if (per > PER_SAT)
                        per = PER_SAT;
                    if (den == 0)
                        stp = STEP_SAT;
                    else
                    begin
                        stp = (longint'(freq) <<< 32) / den;
                        if (stp > STEP_SAT)
                            stp = STEP_SAT;
                    end
                end
                period_len  = per[PER_W-1:0];
                phase_step  = stp[PHASE_W-1:0];
                phase_index = phase_index % period_len;
                return;
            end
            // phase in Q0.32 turns, top two bits pick the quadrant
            ph   = 32'(longint'(phase_index) * longint'(phase_step));
            quad = ph[31:30];
            x    = longint'(ph[29:16]) <<< 16;
            if (quad[0])
                x = ONE_Q30 - x;
            x2 = (x * x) / ONE_Q30;
            r  = C9;
            r  = C7 + (r * x2) / ONE_Q30;
            r  = C5 + (r * x2) / ONE_Q30;
            r  = C3 + (r * x2) / ONE_Q30;
            r  = C1 + (r * x2) / ONE_Q30;
            y  = (r * x) / ONE_Q30;
            if (y < 0)
                y = 0;
            if (y > ONE_Q30)
                y = ONE_Q30;
            s = (y * AMP + HALF_Q30) / ONE_Q30;
            if (quad[1])
                s = -s;
            due_samples.push_back(s[SMP_W-1:0]);
            phase_index = IDX_W'((longint'(phase_index) + 1) % longint'(period_len));
        endfunction

        function void check_sample(logic signed [SMP_W-1:0] got);
            logic signed [SMP_W-1:0] want;
            if (due_samples.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected sample transfer: got %0d", got);
                return;
            end
            want = due_samples.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("sample mismatch: expected %0d, got %0d", want, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    wso_req_if                           req_bus ();
    wso_cfg_if                           cfg_bus ();
    wso_smp_if #(.SAMPLE_BITS(SMP_W))    smp_bus ();

    wavetable_sine_oscillator_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .cfg   (cfg_bus),
        .smp   (smp_bus)
    );

    tone_checker tone = new();
    int          items_sent    = 0;
    int          send_idle_pct = 26;
    int          rcv_idle_pct  = 46;
    int          idle_cycles   = 0;
    bit          hold_ask      = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // transfer monitor, prediction, checking and watchdog
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (smp_bus.valid && smp_bus.ready)
                tone.check_sample(smp_bus.sample);
            if (cfg_bus.valid && cfg_bus.ready)
                tone.rate = cfg_bus.sample_rate;
            if (req_bus.valid && req_bus.ready)
                tone.note_request(req_bus.req_type, req_bus.freq_q4);
            if ((smp_bus.valid && smp_bus.ready) || (cfg_bus.valid && cfg_bus.ready)
                || (req_bus.valid && req_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // sample receiver with random stalls and long hold-offs
    initial
    begin
        int hold_left;
        hold_left     = 0;
        smp_bus.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_ask) begin
                hold_ask  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                smp_bus.ready <= 1'b0;
            end
            else
                smp_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    task automatic send_req(logic req_type, logic [FREQ_W-1:0] freq);
        bit counts;
        counts = !(req_type == REQ_SET && freq == tone.cur_freq);
        while ($urandom_range(99) < send_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.req_type <= req_type;
        req_bus.freq_q4  <= freq;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        @(negedge clk);
        if (counts)
            items_sent++;
        if (items_sent < MODE_SPLIT) begin
            send_idle_pct = 26;
            rcv_idle_pct  = 46;
        end
        else if (items_sent < 2 * MODE_SPLIT) begin
            send_idle_pct = 46;
            rcv_idle_pct  = 26;
        end
        else
        begin
            send_idle_pct = 0;
            rcv_idle_pct  = 0;
        end
    endtask

    task automatic send_tick();
        send_req(REQ_TICK, FREQ_W'($urandom));
    endtask

    task automatic write_rate(logic [RATE_W-1:0] value);
        cfg_bus.valid       <= 1'b1;
        cfg_bus.sample_rate <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // lets a set with no sample behind it finish as well
    task automatic drain();
        req_bus.valid <= 1'b0;
        while (tone.due_samples.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [FREQ_W-1:0] pick_freq();
        longint den;
        int     k;
        den = longint'(tone.rate) * 16;
        k   = $urandom_range(2, 400);
        case ($urandom_range(9))
            0, 1:    return FREQ_W'($urandom);
            2:       return tone.cur_freq;
            3:       return FREQ_W'($urandom_range(16, 2000));
            4:       return ($urandom_range(3) == 0) ? '0 : '1;
            default:
            begin
                if (den / k == 0 || den / k > 262143)
                    return FREQ_W'($urandom);
                return FREQ_W'(den / k);
            end
        endcase
    endfunction

    initial
    begin
        logic [RATE_W-1:0] rate_plan [6];
        int                phase_no;
        int                burst;
        rst_n               = 1'b0;
        req_bus.valid       = 1'b0;
        req_bus.req_type    = REQ_SET;
        req_bus.freq_q4     = '0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.sample_rate = '0;
        rate_plan[0] = RATE_RESET;
        rate_plan[1] = RATE_W'(8000);
        rate_plan[2] = RATE_W'(192000);
        rate_plan[3] = '0;
        rate_plan[4] = RATE_W'($urandom_range(8000, 192000));
        rate_plan[5] = '1;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (phase_no = 0; phase_no < 6; phase_no++) begin
            if (phase_no > 0)
                drain();
            write_rate(rate_plan[phase_no]);
            if (phase_no == 0) begin
                send_tick();
                send_req(REQ_SET, '0);
                send_tick();
                send_req(REQ_SET, FREQ_W'(7040));
                repeat (4) send_tick();
                send_req(REQ_SET, FREQ_W'(7040));
                send_tick();
                // quarter-turn steps hit every quadrant boundary
                send_req(REQ_SET, FREQ_W'(176400));
                repeat (4) send_tick();
                send_req(REQ_SET, '1);
                repeat (2) send_tick();
                send_req(REQ_SET, FREQ_W'(16));
                send_tick();
                send_req(REQ_SET, FREQ_W'(1));
                send_tick();
                send_req(REQ_SET, '0);
                send_tick();
            end
            else
            begin
                // short period and step overflow at low or zero rates
                send_req(REQ_SET, '1);
                repeat (2) send_tick();
                send_req(REQ_SET, FREQ_W'(16));
                send_tick();
            end
            burst = 0;
            while (items_sent < (phase_no + 1) * ITEMS_PER_PHASE) begin
                burst++;
                if (burst == 3)
                    hold_ask = 1'b1;
                if (burst == 6)
                    drain();
                if ($urandom_range(9) != 0)
                    send_req(REQ_SET, pick_freq());
                repeat ($urandom_range(1, 48)) send_tick();
            end
        end

        drain();
        if (tone.due_samples.size() != 0) begin
            $display("%0d samples never arrived", tone.due_samples.size());
            tone.errors++;
        end
        if (tone.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
